>>> sv/srad_pkg.sv
// ----------------------------------------------------------------------------
// Sorted region address decoder package
// Shared types, codes and default sizes for the region decoder core and its
// table cells.
// ----------------------------------------------------------------------------
package srad_pkg;

  // Default sizes handed to the top level.
  localparam int MaxRegionsDef = 16;
  localparam int AddrBitsDef   = 32;

  // Fixed field widths of the item channels.
  localparam int OpW     = 2;
  localparam int IdW     = 8;
  localparam int FieldW  = 32;
  localparam int PosW    = 4;
  localparam int WordIdxW = 30;
  localparam int StatusW = 2;

  // Operation codes carried by an input item.
  typedef enum logic [OpW-1:0] {
    OP_INSERT   = 2'd0,
    OP_DECODE   = 2'd1,
    OP_ABS_WORD = 2'd2,
    OP_ABS_OFFS = 2'd3
  } opcode_e;

  // Result status codes.
  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_MISS  = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  // How the second stage forms the address of a result item.
  typedef enum logic [1:0] {
    MODE_ZERO = 2'd0,
    MODE_SUB  = 2'd1,
    MODE_ADD  = 2'd2
  } mode_e;

  // Compare flags that each table cell hands to its neighbours.
  typedef struct packed {
    logic moves;  // entry is empty or its base lies above the inserted base
    logic le;     // entry is valid and its base is at or below the lookup address
  } cell_flags_t;

endpackage

>>> sv/srad_if.sv
// ----------------------------------------------------------------------------
// Sorted region address decoder channels
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface srad_in_if;
  import srad_pkg::*;

  logic                valid;
  logic                ready;
  logic [OpW-1:0]      opcode;
  logic [IdW-1:0]      new_region_id;
  logic [FieldW-1:0]   new_base;
  logic [FieldW-1:0]   lookup_address;
  logic [PosW-1:0]     table_position;
  logic [WordIdxW-1:0] word_index;
  logic [FieldW-1:0]   local_offset_in;

  modport source (
    output valid, opcode, new_region_id, new_base, lookup_address,
           table_position, word_index, local_offset_in,
    input  ready
  );

  modport sink (
    input  valid, opcode, new_region_id, new_base, lookup_address,
           table_position, word_index, local_offset_in,
    output ready
  );
endinterface

interface srad_out_if;
  import srad_pkg::*;

  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [IdW-1:0]     found_region_id;
  logic [FieldW-1:0]  address_out;

  modport source (
    output valid, status, found_region_id, address_out,
    input  ready
  );

  modport sink (
    input  valid, status, found_region_id, address_out,
    output ready
  );
endinterface

>>> sv/sorted_region_address_decoder_core.sv
// ----------------------------------------------------------------------------
// Sorted region address decoder core
// Keeps a base-ordered table of regions and decodes or builds addresses.
// ----------------------------------------------------------------------------
// Usage: request items arrive on in_i and result items leave on out_o, both
// valid/ready channels; every request item gives exactly one result item.
// The table is a row of MAX_REGIONS cells, one entry each. An insert is
// done in the cycle the item is accepted: every cell compares its base with
// the new one and the upper part of the row shifts one cell to the right.
// Decode and position lookups read the row in the accept cycle; the selected
// entry is registered and the subtract or add happens in a second stage.
// The result item passes the first-stage register and then the output register
// before it shows on out_o and stays there until the receiver takes it. One item
// is accepted every cycle while the receiver keeps up; an item may follow an
// insert directly and sees the updated table. When the receiver stalls, the
// result waits in the output register, one more item waits in the first
// stage, and in_i.ready drops until the output register frees. Reset empties
// the table (the region count goes to zero) and drops both stages; no
// clearing pass is needed, so items are taken from the first cycle after reset.
// ----------------------------------------------------------------------------
module sorted_region_address_decoder_core import srad_pkg::*; #(
  parameter int MAX_REGIONS = MaxRegionsDef,
  parameter int ADDR_BITS   = AddrBitsDef
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  srad_in_if.sink    in_i,
  srad_out_if.source out_o
);

  localparam int CntW = $clog2(MAX_REGIONS + 1);

  // Table row signals.
  logic [ADDR_BITS-1:0] cell_base [MAX_REGIONS];
  logic [IdW-1:0]       cell_id   [MAX_REGIONS];
  cell_flags_t          cell_flags [MAX_REGIONS];
  logic [MAX_REGIONS-1:0] cell_valid;
  logic [MAX_REGIONS-1:0] cell_le;
  logic [MAX_REGIONS-1:0] cell_hit;

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            full;
  logic            in_fire;
  logic            ins_en;
  opcode_e         op;

  logic [ADDR_BITS-1:0] new_base;
  logic [ADDR_BITS-1:0] lookup;

  // Stage registers.
  logic                 s1_v_q, s1_v_d;
  status_e              s1_st_q, s1_st_d;
  logic [IdW-1:0]       s1_id_q, s1_id_d;
  logic [ADDR_BITS-1:0] s1_base_q, s1_base_d;
  logic [ADDR_BITS-1:0] s1_opnd_q, s1_opnd_d;
  mode_e                s1_mode_q, s1_mode_d;

  logic                 out_v_q, out_v_d;
  status_e              out_st_q;
  logic [IdW-1:0]       out_id_q;
  logic [FieldW-1:0]    out_addr_q;
  logic [ADDR_BITS-1:0] s2_res;

  logic out_adv;

  // Handshake: the first stage moves on whenever the output register frees.
  assign out_adv    = !out_v_q || out_o.ready;
  assign in_i.ready = !s1_v_q || out_adv;
  assign in_fire    = in_i.valid && in_i.ready;
  assign op         = opcode_e'(in_i.opcode);
  assign full       = (cnt_q == CntW'(MAX_REGIONS));
  assign ins_en     = in_fire && (op == OP_INSERT) && !full;

  assign new_base = ADDR_BITS'(in_i.new_base);
  assign lookup   = ADDR_BITS'(in_i.lookup_address);

  // Row of table cells, each fed by its left neighbour.
  for (genvar i = 0; i < MAX_REGIONS; i++) begin : g_cell
    logic [ADDR_BITS-1:0] left_base;
    logic [IdW-1:0]       left_id;
    cell_flags_t          left_flags;

    if (i == 0) begin : g_first
      assign left_base  = '0;
      assign left_id    = '0;
      assign left_flags = '0;
    end else begin : g_inner
      assign left_base  = cell_base[i-1];
      assign left_id    = cell_id[i-1];
      assign left_flags = cell_flags[i-1];
    end

    assign cell_valid[i] = (32'(cnt_q) > i);

    srad_cell #(
      .ADDR_BITS(ADDR_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .ins_i       (ins_en),
      .valid_i     (cell_valid[i]),
      .new_base_i  (new_base),
      .new_id_i    (in_i.new_region_id),
      .lookup_i    (lookup),
      .left_base_i (left_base),
      .left_id_i   (left_id),
      .left_flags_i(left_flags),
      .base_o      (cell_base[i]),
      .id_o        (cell_id[i]),
      .flags_o     (cell_flags[i])
    );

    assign cell_le[i] = cell_flags[i].le;

    // The hit is the last cell at or below the address.
    if (i == MAX_REGIONS - 1) begin : g_last_hit
      assign cell_hit[i] = cell_le[i];
    end else begin : g_hit
      assign cell_hit[i] = cell_le[i] && !cell_flags[i+1].le;
    end
  end

  // Region count.
  always_comb begin
    cnt_d = cnt_q;
    if (ins_en) begin
      cnt_d = cnt_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // First stage: select the entry and the operand for the item.
  always_comb begin
    logic [ADDR_BITS-1:0] hit_base;
    logic [IdW-1:0]       hit_id;
    logic [ADDR_BITS-1:0] pos_base;

    hit_base = '0;
    hit_id   = '0;
    pos_base = '0;
    for (int i = 0; i < MAX_REGIONS; i++) begin
      if (cell_hit[i]) begin
        hit_base = hit_base | cell_base[i];
        hit_id   = hit_id | cell_id[i];
      end
      if (32'(in_i.table_position) == i) begin
        pos_base = pos_base | cell_base[i];
      end
    end

    s1_st_d   = ST_OK;
    s1_id_d   = '0;
    s1_base_d = '0;
    s1_opnd_d = '0;
    s1_mode_d = MODE_ZERO;
    unique case (op)
      OP_INSERT: begin
        s1_st_d = full ? ST_FULL : ST_OK;
      end
      OP_DECODE: begin
        if (cell_le == '0) begin
          s1_st_d = ST_MISS;
        end else begin
          s1_id_d   = hit_id;
          s1_base_d = hit_base;
          s1_opnd_d = lookup;
          s1_mode_d = MODE_SUB;
        end
      end
      OP_ABS_WORD, OP_ABS_OFFS: begin
        if (32'(in_i.table_position) >= 32'(cnt_q)) begin
          s1_st_d = ST_RANGE;
        end else begin
          s1_base_d = pos_base;
          s1_mode_d = MODE_ADD;
          if (op == OP_ABS_WORD) begin
            s1_opnd_d = ADDR_BITS'({in_i.word_index, 2'b00});
          end else begin
            s1_opnd_d = ADDR_BITS'(in_i.local_offset_in);
          end
        end
      end
      default: begin
        s1_st_d = ST_OK;
      end
    endcase
  end

  assign s1_v_d  = in_i.ready ? in_i.valid : s1_v_q;
  assign out_v_d = out_adv ? s1_v_q : out_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      s1_v_q  <= s1_v_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_st_q   <= s1_st_d;
      s1_id_q   <= s1_id_d;
      s1_base_q <= s1_base_d;
      s1_opnd_q <= s1_opnd_d;
      s1_mode_q <= s1_mode_d;
    end
  end

  // Second stage: local offset, absolute address or zero, wrapping at ADDR_BITS.
  always_comb begin
    unique case (s1_mode_q)
      MODE_SUB: s2_res = s1_opnd_q - s1_base_q;
      MODE_ADD: s2_res = s1_base_q + s1_opnd_q;
      default:  s2_res = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && s1_v_q) begin
      out_st_q   <= s1_st_q;
      out_id_q   <= s1_id_q;
      out_addr_q <= FieldW'(s2_res);
    end
  end

  assign out_o.valid           = out_v_q;
  assign out_o.status          = out_st_q;
  assign out_o.found_region_id = out_id_q;
  assign out_o.address_out     = out_addr_q;

`ifndef SYNTHESIS
  // The region count never passes the table size.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= MAX_REGIONS)
    else $error("region count beyond table size");

  // An insert into a table that is not full adds exactly one region.
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && (op == OP_INSERT) && !full)
    |=> (cnt_q == $past(cnt_q) + CntW'(1)))
    else $error("insert did not grow the table by one");

  // A failing status always comes with zero id and address.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && (out_st_q != ST_OK)) |-> ((out_id_q == '0) && (out_addr_q == '0)))
    else $error("failing result carries data");

  // With both stages held by a stalled receiver no item is taken.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && out_v_q && !out_o.ready) |-> !in_i.ready)
    else $error("item accepted while the pipeline is full");
`endif

endmodule

>>> sv/srad_cell.sv
// ----------------------------------------------------------------------------
// Region table cell
// Holds one table entry, compares it against the broadcast insert base and
// lookup address, and on an insert either keeps its entry, takes the entry
// of its left neighbour or loads the new region.
// ----------------------------------------------------------------------------
module srad_cell import srad_pkg::*; #(
  parameter int ADDR_BITS = AddrBitsDef
) (
  input  logic                 clk_i,
  input  logic                 ins_i,
  input  logic                 valid_i,
  input  logic [ADDR_BITS-1:0] new_base_i,
  input  logic [IdW-1:0]       new_id_i,
  input  logic [ADDR_BITS-1:0] lookup_i,
  input  logic [ADDR_BITS-1:0] left_base_i,
  input  logic [IdW-1:0]       left_id_i,
  input  cell_flags_t          left_flags_i,
  output logic [ADDR_BITS-1:0] base_o,
  output logic [IdW-1:0]       id_o,
  output cell_flags_t          flags_o
);

  logic [ADDR_BITS-1:0] base_q, base_d;
  logic [IdW-1:0]       id_q, id_d;

  // Compare the held entry with both broadcast addresses.
  always_comb begin
    flags_o.moves = !valid_i || (base_q > new_base_i);
    flags_o.le    = valid_i && (base_q <= lookup_i);
  end

  // An entry above the new base shifts right; the leftmost moving cell
  // takes the new region, the others take their neighbour's entry.
  always_comb begin
    base_d = base_q;
    id_d   = id_q;
    if (ins_i && flags_o.moves) begin
      if (left_flags_i.moves) begin
        base_d = left_base_i;
        id_d   = left_id_i;
      end else begin
        base_d = new_base_i;
        id_d   = new_id_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    id_q   <= id_d;
  end

  assign base_o = base_q;
  assign id_o   = id_q;

endmodule

>>> tb/sorted_region_address_decoder_core_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted region address decoder checker
// Watches the request and result channels and keeps its own copy of the
// region table. Every accepted request item is predicted into an expected
// result item, and results are compared field by field in arrival order.
// ----------------------------------------------------------------------------
module sorted_region_address_decoder_core_checker import srad_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  srad_in_if   req,
  srad_out_if  rsp,
  output int   mismatches_o,
  output int   outstanding_o,
  output int   results_o,
  output int   flagged_o
);

  localparam int Slots = MaxRegionsDef;

  typedef struct packed {
    status_e           status;
    logic [IdW-1:0]    id;
    logic [FieldW-1:0] addr;
  } region_result_t;

  // Shadow of the region table, kept in ascending base order.
  logic [FieldW-1:0] shadow_base [Slots];
  logic [IdW-1:0]    shadow_id   [Slots];
  int                shadow_used;

  region_result_t awaited_results [$];
  int             mism;
  int             seen;
  int             flags;

  // Works out the result of one request item and updates the shadow table.
  function automatic region_result_t apply_request(
    opcode_e op, logic [IdW-1:0] nid, logic [FieldW-1:0] nb, logic [FieldW-1:0] la,
    logic [PosW-1:0] pos, logic [WordIdxW-1:0] widx, logic [FieldW-1:0] offs
  );
    region_result_t    r;
    int                slot;
    logic [FieldW-1:0] add;
    r.status = ST_OK;
    r.id     = '0;
    r.addr   = '0;
    case (op)
      OP_INSERT: begin
        if (shadow_used >= Slots) begin
          r.status = ST_FULL;
        end else begin
          // Entries with a higher base move up; equal bases stay underneath.
          slot = shadow_used;
          while (slot > 0 && shadow_base[slot-1] > nb) begin
            shadow_base[slot] = shadow_base[slot-1];
            shadow_id[slot]   = shadow_id[slot-1];
            slot--;
          end
          shadow_base[slot] = nb;
          shadow_id[slot]   = nid;
          shadow_used++;
        end
      end
      OP_DECODE: begin
        // The last entry at or below the address wins, so equal bases pick the newest.
        slot = -1;
        for (int i = 0; i < shadow_used; i++) begin
          if (shadow_base[i] <= la) slot = i;
        end
        if (slot < 0) begin
          r.status = ST_MISS;
        end else begin
          r.id   = shadow_id[slot];
          r.addr = la - shadow_base[slot];
        end
      end
      default: begin
        if (int'(pos) >= shadow_used) begin
          r.status = ST_RANGE;
        end else begin
          add    = (op == OP_ABS_WORD) ? {widx, 2'b00} : offs;
          r.addr = shadow_base[pos] + add;
        end
      end
    endcase
    return r;
  endfunction

  // Prints one line for a mismatch and counts it.
  task automatic report_mismatch(input string what, input logic [FieldW-1:0] got,
                                 input logic [FieldW-1:0] want);
    mism++;
    $display("%0t: result %0d, %s: got 0x%0h, expected 0x%0h", $time, seen, what, got, want);
  endtask

  // Results are checked before the request of the same edge is predicted.
  always @(posedge clk_i or negedge rst_ni) begin
    region_result_t want;
    if (!rst_ni) begin
      shadow_used = 0;
      awaited_results.delete();
      mism  = 0;
      seen  = 0;
      flags = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        seen++;
        if (awaited_results.size() == 0) begin
          report_mismatch("result item with none expected", rsp.address_out, '0);
        end else begin
          want = awaited_results.pop_front();
          if (want.status != ST_OK) flags++;
          if (rsp.status !== want.status) begin
            report_mismatch("status", FieldW'(rsp.status), FieldW'(want.status));
          end
          if (rsp.found_region_id !== want.id) begin
            report_mismatch("found_region_id", FieldW'(rsp.found_region_id), FieldW'(want.id));
          end
          if (rsp.address_out !== want.addr) begin
            report_mismatch("address_out", rsp.address_out, want.addr);
          end
        end
      end
      if (req.valid && req.ready) begin
        awaited_results.insert(awaited_results.size(),
                               apply_request(opcode_e'(req.opcode), req.new_region_id,
                                             req.new_base, req.lookup_address,
                                             req.table_position, req.word_index,
                                             req.local_offset_in));
      end
    end
    mismatches_o  <= mism;
    outstanding_o <= awaited_results.size();
    results_o     <= seen;
    flagged_o     <= flags;
  end

endmodule

>>> tb/sorted_region_address_decoder_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted region address decoder test
// Drives request items into the decoder core with random gaps, stalls the
// result channel at random, and takes the verdict from the checker beside it.
// A directed opening covers empty-table, boundary and equal-base cases; the
// random part grows the table to full and then keeps decoding and building
// addresses aimed at the stored bases.
// ----------------------------------------------------------------------------
module sorted_region_address_decoder_core_test;
  import srad_pkg::*;

  localparam int IdlePct     = 24;
  localparam int RandomItems = 1200;
  localparam int CalmFrom    = 500;
  localparam int CalmTo      = 700;
  localparam int StallLimit  = 2000;
  localparam int SettleTime  = 10;

  logic clk_i;
  logic rst_ni;
  bit   calm;
  int   items_sent;
  int   directed_items;
  int   quiet_cycles;
  int   mismatches;
  int   outstanding;
  int   results_checked;
  int   flagged;

  // Bases inserted so far, used to aim decodes near real regions and to repeat bases.
  logic [FieldW-1:0] known_bases [$];

  srad_in_if  req_if ();
  srad_out_if rsp_if ();

  sorted_region_address_decoder_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  sorted_region_address_decoder_core_checker region_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req           (req_if),
    .rsp           (rsp_if),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding),
    .results_o     (results_checked),
    .flagged_o     (flagged)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // The result side stalls at random except during the calm stretch.
  always @(posedge clk_i) begin
    rsp_if.ready <= calm || ($urandom_range(99) >= IdlePct);
  end

  // Ends the run when no item moves on either channel for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("No item moved for %0d cycles; %0d results still awaited.",
               quiet_cycles, outstanding);
      $display("sorted_region_address_decoder_core: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Random values sized to the narrow request fields.
  function automatic logic [IdW-1:0] rnd_id();
    return IdW'($urandom);
  endfunction

  function automatic logic [PosW-1:0] rnd_pos();
    return PosW'($urandom);
  endfunction

  function automatic logic [WordIdxW-1:0] rnd_wix();
    return WordIdxW'($urandom);
  endfunction

  // Offers one request item after a random gap and waits until it is taken.
  task automatic send_request(opcode_e op, logic [IdW-1:0] nid, logic [FieldW-1:0] nb,
                              logic [FieldW-1:0] la, logic [PosW-1:0] pos,
                              logic [WordIdxW-1:0] widx, logic [FieldW-1:0] offs);
    while (!calm && $urandom_range(99) < IdlePct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid           <= 1'b1;
    req_if.opcode          <= op;
    req_if.new_region_id   <= nid;
    req_if.new_base        <= nb;
    req_if.lookup_address  <= la;
    req_if.table_position  <= pos;
    req_if.word_index      <= widx;
    req_if.local_offset_in <= offs;
    do @(posedge clk_i); while (!req_if.ready);
    items_sent++;
    if (op == OP_INSERT && known_bases.size() < MaxRegionsDef) begin
      known_bases.insert(known_bases.size(), nb);
    end
  endtask

  // Picks an address close to a stored base, or anywhere at all.
  function automatic logic [FieldW-1:0] aimed_address();
    logic [FieldW-1:0] b;
    int                sel;
    sel = $urandom_range(9);
    if (known_bases.size() == 0 || sel < 2) return $urandom;
    b = known_bases[$urandom_range(known_bases.size() - 1)];
    case (sel)
      2, 3:    return b;
      4, 5, 6: return b + $urandom_range(4095);
      7:       return b - 1;
      default: return b + $urandom;
    endcase
  endfunction

  // Picks a base for a new region: anywhere, a repeat, near zero or near the top.
  function automatic logic [FieldW-1:0] new_region_base();
    case ($urandom_range(3))
      0:       return $urandom;
      1:       return (known_bases.size() == 0) ? $urandom :
                      known_bases[$urandom_range(known_bases.size() - 1)];
      2:       return $urandom_range(255);
      default: return {8'hFF, 24'($urandom)};
    endcase
  endfunction

  // Stimulus and verdict.
  initial begin
    int pick;
    int insert_pct;
    rst_ni                 <= 1'b0;
    req_if.valid           <= 1'b0;
    req_if.opcode          <= OP_INSERT;
    req_if.new_region_id   <= '0;
    req_if.new_base        <= '0;
    req_if.lookup_address  <= '0;
    req_if.table_position  <= '0;
    req_if.word_index      <= '0;
    req_if.local_offset_in <= '0;
    calm       = 1'b0;
    items_sent = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty table: decode misses and every position is out of range.
    send_request(OP_DECODE, rnd_id(), $urandom, 32'h0000_1234, rnd_pos(), rnd_wix(),
                 $urandom);
    send_request(OP_ABS_WORD, rnd_id(), $urandom, $urandom, 4'd0, 30'h1, $urandom);
    send_request(OP_ABS_OFFS, rnd_id(), $urandom, $urandom, 4'd15, rnd_wix(), 32'h10);
    // One region: below its base misses, its base hits with a zero offset.
    send_request(OP_INSERT, 8'h5A, 32'h8000_0000, $urandom, rnd_pos(), rnd_wix(), $urandom);
    send_request(OP_DECODE, rnd_id(), $urandom, 32'h7FFF_FFFF, rnd_pos(), rnd_wix(),
                 $urandom);
    send_request(OP_DECODE, rnd_id(), $urandom, 32'h8000_0000, rnd_pos(), rnd_wix(),
                 $urandom);
    // Extreme bases and ids, then a second region on an equal base.
    send_request(OP_INSERT, 8'hFF, 32'hFFFF_FFFF, $urandom, rnd_pos(), rnd_wix(), $urandom);
    send_request(OP_INSERT, 8'h00, 32'h0000_0000, $urandom, rnd_pos(), rnd_wix(), $urandom);
    send_request(OP_INSERT, 8'hA5, 32'h8000_0000, $urandom, rnd_pos(), rnd_wix(), $urandom);
    send_request(OP_DECODE, rnd_id(), $urandom, 32'h8000_0010, rnd_pos(), rnd_wix(),
                 $urandom);
    send_request(OP_DECODE, rnd_id(), $urandom, 32'hFFFF_FFFF, rnd_pos(), rnd_wix(),
                 $urandom);
    send_request(OP_DECODE, rnd_id(), $urandom, 32'h0000_0000, rnd_pos(), rnd_wix(),
                 $urandom);
    // Absolute addresses that wrap past the top, a zero add, and the first bad position.
    send_request(OP_ABS_WORD, rnd_id(), $urandom, $urandom, 4'd3, 30'h3FFF_FFFF, $urandom);
    send_request(OP_ABS_OFFS, rnd_id(), $urandom, $urandom, 4'd3, rnd_wix(), 32'hFFFF_FFFF);
    send_request(OP_ABS_WORD, rnd_id(), $urandom, $urandom, 4'd0, 30'h0, $urandom);
    send_request(OP_ABS_OFFS, rnd_id(), $urandom, $urandom, 4'd4, rnd_wix(), 32'h0);
    send_request(OP_ABS_WORD, rnd_id(), $urandom, $urandom, 4'd1, 30'h1, $urandom);
    directed_items = items_sent;

    // Random part: the table fills early, after which inserts report it full.
    for (int n = 0; n < RandomItems; n++) begin
      calm       = (n >= CalmFrom && n < CalmTo);
      insert_pct = (known_bases.size() < MaxRegionsDef) ? 8 : 5;
      pick       = $urandom_range(99);
      if (pick < insert_pct) begin
        send_request(OP_INSERT, rnd_id(), new_region_base(), $urandom, rnd_pos(), rnd_wix(),
                     $urandom);
      end else if (pick < 50) begin
        send_request(OP_DECODE, rnd_id(), $urandom, aimed_address(), rnd_pos(), rnd_wix(),
                     $urandom);
      end else if (pick < 75) begin
        send_request(OP_ABS_WORD, rnd_id(), $urandom, $urandom, rnd_pos(), rnd_wix(),
                     $urandom);
      end else begin
        send_request(OP_ABS_OFFS, rnd_id(), $urandom, $urandom, rnd_pos(), rnd_wix(),
                     $urandom);
      end
    end
    calm = 1'b0;
    req_if.valid <= 1'b0;

    // Drain the remaining results, then wait out SettleTime for strays.
    do @(posedge clk_i); while (outstanding != 0);
    repeat (SettleTime) @(posedge clk_i);

    $display("Sent %0d request items (%0d directed) and checked %0d result items.",
             items_sent, directed_items, results_checked);
    $display("%0d results carried a miss, full or bad-position flag; %0d regions were stored.",
             flagged, known_bases.size());
    if (mismatches == 0 && outstanding == 0) begin
      $display("sorted_region_address_decoder_core: match");
    end else begin
      $display("%0d field mismatches, %0d results never arrived.", mismatches, outstanding);
      $display("sorted_region_address_decoder_core: mismatch");
    end
    $finish;
  end

endmodule

>>> sorted_region_address_decoder_core.f
sv/srad_pkg.sv
sv/srad_if.sv
sv/srad_cell.sv
sv/sorted_region_address_decoder_core.sv
tb/sorted_region_address_decoder_core_checker.sv
tb/sorted_region_address_decoder_core_test.sv
